/* src/qslerp_pkg.sv */
`default_nettype none

package qslerp_pkg;

    // Fraction bits of the slerp weights.
    localparam int FRAC_BITS = 15;
    // Fraction bits of the blend factor and of the quaternion components.
    localparam int BLEND_BITS = 15;
    localparam int BLEND_W = BLEND_BITS + 2;
    localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << BLEND_BITS;

    localparam int COMP_W = 16;
    localparam int PROD_W = 2 * COMP_W;
    // Dot product of four products, and its magnitude.
    localparam int DOT_W = PROD_W + 2;
    localparam int COSA_W = DOT_W - 1;
    // Cosine and sine of a unit angle, Q.30, nonnegative.
    localparam int SINE_W = 31;
    localparam int SQ_W = 2 * SINE_W - 1;
    localparam int SQRT_STEPS = SINE_W;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W = 35;
    localparam int ANG_W = 34;
    localparam logic [30:0] CORDIC_GAIN = 31'd652032874;
    localparam logic [30:0] ATAN_Q30 [CORDIC_STEPS] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
        31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
        31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535,
        31'd32767, 31'd16383, 31'd8191, 31'd4095, 31'd2047,
        31'd1023, 31'd511, 31'd255, 31'd127, 31'd63,
        31'd31, 31'd15, 31'd8, 31'd4, 31'd2
    };

    // Weights are clamped to plus or minus four.
    localparam int DIV_STEPS = FRAC_BITS + 4;
    localparam int WGT_W = FRAC_BITS + 4;
    localparam int DIV_LAT = DIV_STEPS + 2;

    // Data that travels alongside the arithmetic of every stage.
    typedef struct packed {
        logic [3:0][COMP_W-1:0] a;
        logic [3:0][COMP_W-1:0] b;
        logic [BLEND_W-1:0]     t;
        logic                   neg;
        logic                   lin;
        logic [SINE_W-1:0]      sine;
    } side_t;

endpackage

`default_nettype wire

/* src/qslerp_sine.sv */
`default_nettype none

// Rotation CORDIC: sine of a Q.30 angle, one iteration per stage.
module qslerp_sine (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [qslerp_pkg::ANG_W-1:0]    angle,
    output logic signed [qslerp_pkg::CORDIC_W-1:0] sine
);

    logic signed [qslerp_pkg::CORDIC_W-1:0] x_reg [qslerp_pkg::CORDIC_STEPS];
    logic signed [qslerp_pkg::CORDIC_W-1:0] y_reg [qslerp_pkg::CORDIC_STEPS];
    logic signed [qslerp_pkg::ANG_W-1:0]    z_reg [qslerp_pkg::CORDIC_STEPS];

    for (genvar k = 0; k < qslerp_pkg::CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [qslerp_pkg::ANG_W-1:0] ATAN =
            qslerp_pkg::ANG_W'(qslerp_pkg::ATAN_Q30[k]);
        logic signed [qslerp_pkg::CORDIC_W-1:0] x_in, y_in, dx, dy;
        logic signed [qslerp_pkg::ANG_W-1:0]    z_in;

        if (k == 0) begin : g_first
            assign x_in = qslerp_pkg::CORDIC_W'(qslerp_pkg::CORDIC_GAIN);
            assign y_in = '0;
            assign z_in = angle;
        end else begin : g_next
            assign x_in = x_reg[k-1];
            assign y_in = y_reg[k-1];
            assign z_in = z_reg[k-1];
        end

        // Shifts round toward minus infinity.
        assign dx = y_in >>> k;
        assign dy = x_in >>> k;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_in >= 0) begin
                    x_reg[k] <= x_in - dx;
                    y_reg[k] <= y_in + dy;
                    z_reg[k] <= z_in - ATAN;
                end else begin
                    x_reg[k] <= x_in + dx;
                    y_reg[k] <= y_in - dy;
                    z_reg[k] <= z_in + ATAN;
                end
            end
        end
    end

    assign sine = y_reg[qslerp_pkg::CORDIC_STEPS-1];

endmodule

`default_nettype wire

/* src/qslerp_div.sv */
`default_nettype none

// Restoring divider for one weight: (num * 2^FRAC_BITS) / den, truncated toward
// zero and clamped to plus or minus four. One quotient bit per stage.
module qslerp_div (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [qslerp_pkg::CORDIC_W-1:0] num,
    input  logic [qslerp_pkg::SINE_W-1:0]          den,
    output logic signed [qslerp_pkg::WGT_W-1:0]    weight
);

    localparam int RW = qslerp_pkg::CORDIC_W + qslerp_pkg::FRAC_BITS + 1;
    localparam int QW = qslerp_pkg::DIV_STEPS;
    localparam logic [QW-1:0] LIM = QW'(1) << (qslerp_pkg::FRAC_BITS + 2);

    logic [qslerp_pkg::CORDIC_W-1:0] mag;
    logic [RW-1:0] rem0_reg;
    logic [qslerp_pkg::SINE_W-1:0] den0_reg;
    logic sign0_reg, ovf0_reg;

    logic [RW-1:0]                 rem_reg  [QW];
    logic [QW-1:0]                 q_reg    [QW];
    logic [qslerp_pkg::SINE_W-1:0] den_reg  [QW];
    logic                          sign_reg [QW];
    logic                          ovf_reg  [QW];

    logic [QW-1:0] qmag;
    logic signed [qslerp_pkg::WGT_W-1:0] weight_reg;

    // Setup: magnitude, sign and a quotient that is known to overflow.
    assign mag = (num < 0) ? qslerp_pkg::CORDIC_W'(-num) : qslerp_pkg::CORDIC_W'(num);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg  <= RW'(mag) << qslerp_pkg::FRAC_BITS;
            den0_reg  <= den;
            sign0_reg <= num < 0;
            ovf0_reg  <= RW'(mag) >= (RW'(den) << (QW - qslerp_pkg::FRAC_BITS));
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int J = QW - 1 - k;
        logic [RW-1:0] rem_in, sub;
        logic [QW-1:0] q_in;
        logic [qslerp_pkg::SINE_W-1:0] den_in;
        logic sign_in, ovf_in;

        if (k == 0) begin : g_first
            assign rem_in  = rem0_reg;
            assign q_in    = '0;
            assign den_in  = den0_reg;
            assign sign_in = sign0_reg;
            assign ovf_in  = ovf0_reg;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign sign_in = sign_reg[k-1];
            assign ovf_in  = ovf_reg[k-1];
        end

        assign sub = RW'(den_in) << J;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_in >= sub) begin
                    rem_reg[k] <= rem_in - sub;
                    q_reg[k]   <= q_in | (QW'(1) << J);
                end else begin
                    rem_reg[k] <= rem_in;
                    q_reg[k]   <= q_in;
                end
                den_reg[k]  <= den_in;
                sign_reg[k] <= sign_in;
                ovf_reg[k]  <= ovf_in;
            end
        end
    end

    // Clamp the magnitude and restore the sign.
    assign qmag = (ovf_reg[QW-1] || (q_reg[QW-1] > LIM)) ? LIM : q_reg[QW-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            weight_reg <= sign_reg[QW-1] ? -qslerp_pkg::WGT_W'(qmag)
                                         : qslerp_pkg::WGT_W'(qmag);
        end
    end

    assign weight = weight_reg;

endmodule

`default_nettype wire

/* src/quaternion_slerp.sv */
`default_nettype none

// Quaternion slerp in Q1.15 fixed point.
// Input channel s_*: one item per handshake carries quaternions a and b and
// the blend factor t. Output channel m_*: one item per input item with the
// interpolated quaternion in m_tdata and the linear-path flag in m_tuser.
// cfg_wr_en/cfg_wr_data write the closeness threshold; write it only while
// no item is in flight.
// Throughput is one item per cycle unless the output buffer is full. An
// accepted input reaches m_tvalid through 3 dot-product stages, 31 square-root
// stages, 30 vectoring CORDIC stages, 2 angle-scaling stages, 30 sine CORDIC
// stages, 21 divider stages, 2 output-product stages and the output register.
// A two-entry output buffer lets the pipeline keep accepting while one
// result waits; s_tready drops only when both entries are full, and the
// whole pipeline then holds its contents.
// Reset (aresetn low at a clock edge) empties the pipeline and sets the
// threshold to 33.
module quaternion_slerp (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_w, out_x, out_y, out_z
    output logic [63:0]  m_tdata,
    // used_linear
    output logic [0:0]   m_tuser
);

    localparam int LIN_W = qslerp_pkg::COSA_W + 2;
    localparam logic [qslerp_pkg::COSA_W-1:0] Q30_ONE = qslerp_pkg::COSA_W'(1) << 30;
    localparam logic [2*qslerp_pkg::SINE_W-1:0] Q60_ONE =
        (2 * qslerp_pkg::SINE_W)'(1) << 60;
    localparam int MUL_W = qslerp_pkg::ANG_W + qslerp_pkg::BLEND_W + 1;
    localparam int WP_W = qslerp_pkg::COMP_W + qslerp_pkg::WGT_W;
    localparam int SUM_W = WP_W + 1;

    logic en;
    logic skid_vld_reg;

    // The pipeline advances unless the output buffer is full.
    assign en = !skid_vld_reg;
    assign s_tready = en;

    // Closeness threshold register.
    logic [15:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 16'd33;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Unpack the input item and clamp the blend factor to one.
    qslerp_pkg::side_t in_side;
    logic [15:0] blend;

    assign blend = s_tdata[143:128];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_side.a[i] = s_tdata[16*i +: 16];
            in_side.b[i] = s_tdata[64+16*i +: 16];
        end
        in_side.t    = (blend > 16'd32768) ? qslerp_pkg::BLEND_ONE
                                           : qslerp_pkg::BLEND_W'(blend);
        in_side.neg  = 1'b0;
        in_side.lin  = 1'b0;
        in_side.sine = '0;
    end

    // Stage 1: component products of the dot product.
    logic p1_vld_reg;
    qslerp_pkg::side_t p1_side_reg;
    logic signed [qslerp_pkg::PROD_W-1:0] p1_prod_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_side_reg <= in_side;
            for (int i = 0; i < 4; i++) begin
                p1_prod_reg[i] <= $signed(in_side.a[i]) * $signed(in_side.b[i]);
            end
        end
    end

    // Stage 2: sum and magnitude of the cosine.
    logic signed [qslerp_pkg::DOT_W-1:0] dot;
    logic p2_vld_reg;
    qslerp_pkg::side_t p2_side_next;
    qslerp_pkg::side_t p2_side_reg;
    logic [qslerp_pkg::COSA_W-1:0] p2_cos_reg;

    assign dot = qslerp_pkg::DOT_W'(p1_prod_reg[0]) + qslerp_pkg::DOT_W'(p1_prod_reg[1])
               + qslerp_pkg::DOT_W'(p1_prod_reg[2]) + qslerp_pkg::DOT_W'(p1_prod_reg[3]);

    always_comb begin
        p2_side_next     = p1_side_reg;
        p2_side_next.neg = dot < 0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (en) begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_side_reg <= p2_side_next;
            p2_cos_reg  <= (dot < 0) ? qslerp_pkg::COSA_W'(-dot)
                                     : qslerp_pkg::COSA_W'(dot);
        end
    end

    // Stage 3: linear-path decision and the radicand one minus cosine squared.
    logic signed [LIN_W-1:0] gap, thr_term;
    logic [2*qslerp_pkg::SINE_W-1:0] csq;
    logic p3_vld_reg;
    qslerp_pkg::side_t p3_side_next;
    qslerp_pkg::side_t p3_side_reg;
    logic [qslerp_pkg::SQ_W-1:0] p3_rad_reg;
    logic [qslerp_pkg::SINE_W-1:0] p3_cos_reg;

    assign gap = LIN_W'(Q30_ONE) - LIN_W'(p2_cos_reg);
    assign thr_term = LIN_W'(thr_reg) << qslerp_pkg::BLEND_BITS;
    assign csq = p2_cos_reg[qslerp_pkg::SINE_W-1:0] * p2_cos_reg[qslerp_pkg::SINE_W-1:0];

    always_comb begin
        p3_side_next     = p2_side_reg;
        p3_side_next.lin = gap < thr_term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_vld_reg <= 1'b0;
        end else if (en) begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_side_reg <= p3_side_next;
            p3_rad_reg  <= qslerp_pkg::SQ_W'(Q60_ONE - csq);
            p3_cos_reg  <= p2_cos_reg[qslerp_pkg::SINE_W-1:0];
        end
    end

    // Integer square root of the radicand, one result bit per stage.
    logic [qslerp_pkg::SQ_W-1:0]   sq_v_reg    [qslerp_pkg::SQRT_STEPS];
    logic [qslerp_pkg::SQ_W-1:0]   sq_res_reg  [qslerp_pkg::SQRT_STEPS];
    logic [qslerp_pkg::SINE_W-1:0] sq_cos_reg  [qslerp_pkg::SQRT_STEPS];
    qslerp_pkg::side_t             sq_side_reg [qslerp_pkg::SQRT_STEPS];
    logic                          sq_vld_reg  [qslerp_pkg::SQRT_STEPS];

    for (genvar k = 0; k < qslerp_pkg::SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [qslerp_pkg::SQ_W:0] ROOT_BIT =
            (qslerp_pkg::SQ_W + 1)'(1) << (2 * (qslerp_pkg::SQRT_STEPS - 1 - k));
        logic [qslerp_pkg::SQ_W-1:0] v_in, res_in;
        logic [qslerp_pkg::SINE_W-1:0] c_in;
        qslerp_pkg::side_t s_in;
        logic vl_in;
        logic [qslerp_pkg::SQ_W:0] trial;

        if (k == 0) begin : g_first
            assign v_in   = p3_rad_reg;
            assign res_in = '0;
            assign c_in   = p3_cos_reg;
            assign s_in   = p3_side_reg;
            assign vl_in  = p3_vld_reg;
        end else begin : g_next
            assign v_in   = sq_v_reg[k-1];
            assign res_in = sq_res_reg[k-1];
            assign c_in   = sq_cos_reg[k-1];
            assign s_in   = sq_side_reg[k-1];
            assign vl_in  = sq_vld_reg[k-1];
        end

        assign trial = {1'b0, res_in} + ROOT_BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[k] <= vl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, v_in} >= trial) begin
                    sq_v_reg[k]   <= qslerp_pkg::SQ_W'({1'b0, v_in} - trial);
                    sq_res_reg[k] <= qslerp_pkg::SQ_W'({1'b0, res_in >> 1} + ROOT_BIT);
                end else begin
                    sq_v_reg[k]   <= v_in;
                    sq_res_reg[k] <= res_in >> 1;
                end
                sq_cos_reg[k]  <= c_in;
                sq_side_reg[k] <= s_in;
            end
        end
    end

    // Vectoring CORDIC: theta = atan2(sine, cosine), one iteration per stage.
    logic signed [qslerp_pkg::CORDIC_W-1:0] vx_reg [qslerp_pkg::CORDIC_STEPS];
    logic signed [qslerp_pkg::CORDIC_W-1:0] vy_reg [qslerp_pkg::CORDIC_STEPS];
    logic signed [qslerp_pkg::ANG_W-1:0]    vz_reg [qslerp_pkg::CORDIC_STEPS];
    qslerp_pkg::side_t                      v_side_reg [qslerp_pkg::CORDIC_STEPS];
    logic                                   v_vld_reg  [qslerp_pkg::CORDIC_STEPS];

    for (genvar k = 0; k < qslerp_pkg::CORDIC_STEPS; k++) begin : g_vec
        localparam logic signed [qslerp_pkg::ANG_W-1:0] ATAN =
            qslerp_pkg::ANG_W'(qslerp_pkg::ATAN_Q30[k]);
        logic signed [qslerp_pkg::CORDIC_W-1:0] x_in, y_in, dx, dy;
        logic signed [qslerp_pkg::ANG_W-1:0] z_in;
        qslerp_pkg::side_t s_in;
        logic vl_in;

        if (k == 0) begin : g_first
            logic [qslerp_pkg::SINE_W-1:0] root;
            assign root = sq_res_reg[qslerp_pkg::SQRT_STEPS-1][qslerp_pkg::SINE_W-1:0];
            assign x_in = qslerp_pkg::CORDIC_W'(sq_cos_reg[qslerp_pkg::SQRT_STEPS-1]);
            assign y_in = qslerp_pkg::CORDIC_W'(root);
            assign z_in = '0;
            assign vl_in = sq_vld_reg[qslerp_pkg::SQRT_STEPS-1];
            // A zero sine falls back to the linear blend.
            always_comb begin
                s_in      = sq_side_reg[qslerp_pkg::SQRT_STEPS-1];
                s_in.sine = root;
                s_in.lin  = s_in.lin || (root == '0);
            end
        end else begin : g_next
            assign x_in  = vx_reg[k-1];
            assign y_in  = vy_reg[k-1];
            assign z_in  = vz_reg[k-1];
            assign s_in  = v_side_reg[k-1];
            assign vl_in = v_vld_reg[k-1];
        end

        assign dx = y_in >>> k;
        assign dy = x_in >>> k;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_vld_reg[k] <= 1'b0;
            end else if (en) begin
                v_vld_reg[k] <= vl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_in > 0) begin
                    vx_reg[k] <= x_in + dx;
                    vy_reg[k] <= y_in - dy;
                    vz_reg[k] <= z_in + ATAN;
                end else begin
                    vx_reg[k] <= x_in - dx;
                    vy_reg[k] <= y_in + dy;
                    vz_reg[k] <= z_in - ATAN;
                end
                v_side_reg[k] <= s_in;
            end
        end
    end

    // Stage M1: t * theta.
    logic m1_vld_reg;
    qslerp_pkg::side_t m1_side_reg;
    logic signed [MUL_W-1:0] m1_prod_reg;
    logic signed [qslerp_pkg::ANG_W-1:0] m1_theta_reg;
    logic signed [qslerp_pkg::ANG_W-1:0] theta;

    assign theta = vz_reg[qslerp_pkg::CORDIC_STEPS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
        end else if (en) begin
            m1_vld_reg <= v_vld_reg[qslerp_pkg::CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_side_reg  <= v_side_reg[qslerp_pkg::CORDIC_STEPS-1];
            m1_prod_reg  <= $signed({1'b0, v_side_reg[qslerp_pkg::CORDIC_STEPS-1].t}) * theta;
            m1_theta_reg <= theta;
        end
    end

    // Stage M2: angles of the two sines, quotient truncated toward zero.
    localparam logic signed [MUL_W-1:0] TRUNC_BIAS =
        (MUL_W'(1) << qslerp_pkg::BLEND_BITS) - MUL_W'(1);
    logic signed [MUL_W-1:0] scaled;
    logic signed [qslerp_pkg::ANG_W-1:0] ang_b;
    logic m2_vld_reg;
    qslerp_pkg::side_t m2_side_reg;
    logic signed [qslerp_pkg::ANG_W-1:0] m2_ang_a_reg, m2_ang_b_reg;

    assign scaled = (m1_prod_reg + ((m1_prod_reg < 0) ? TRUNC_BIAS : '0))
                    >>> qslerp_pkg::BLEND_BITS;
    assign ang_b = scaled[qslerp_pkg::ANG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (en) begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_side_reg  <= m1_side_reg;
            m2_ang_b_reg <= ang_b;
            m2_ang_a_reg <= m1_theta_reg - ang_b;
        end
    end

    // Sines of both angles; side data is delayed alongside.
    logic signed [qslerp_pkg::CORDIC_W-1:0] sin_a, sin_b;
    qslerp_pkg::side_t r_side_reg [qslerp_pkg::CORDIC_STEPS];
    logic              r_vld_reg  [qslerp_pkg::CORDIC_STEPS];

    qslerp_sine u_sine_a (
        .aclk  (aclk),
        .en    (en),
        .angle (m2_ang_a_reg),
        .sine  (sin_a)
    );

    qslerp_sine u_sine_b (
        .aclk  (aclk),
        .en    (en),
        .angle (m2_ang_b_reg),
        .sine  (sin_b)
    );

    for (genvar k = 0; k < qslerp_pkg::CORDIC_STEPS; k++) begin : g_rot_side
        qslerp_pkg::side_t s_in;
        logic vl_in;
        if (k == 0) begin : g_first
            assign s_in  = m2_side_reg;
            assign vl_in = m2_vld_reg;
        end else begin : g_next
            assign s_in  = r_side_reg[k-1];
            assign vl_in = r_vld_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                r_vld_reg[k] <= 1'b0;
            end else if (en) begin
                r_vld_reg[k] <= vl_in;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                r_side_reg[k] <= s_in;
            end
        end
    end

    // Weights: sine over sin(theta).
    logic signed [qslerp_pkg::WGT_W-1:0] div_wa, div_wb;
    qslerp_pkg::side_t d_side_reg [qslerp_pkg::DIV_LAT];
    logic              d_vld_reg  [qslerp_pkg::DIV_LAT];

    qslerp_div u_div_a (
        .aclk   (aclk),
        .en     (en),
        .num    (sin_a),
        .den    (r_side_reg[qslerp_pkg::CORDIC_STEPS-1].sine),
        .weight (div_wa)
    );

    qslerp_div u_div_b (
        .aclk   (aclk),
        .en     (en),
        .num    (sin_b),
        .den    (r_side_reg[qslerp_pkg::CORDIC_STEPS-1].sine),
        .weight (div_wb)
    );

    for (genvar k = 0; k < qslerp_pkg::DIV_LAT; k++) begin : g_div_side
        qslerp_pkg::side_t s_in;
        logic vl_in;
        if (k == 0) begin : g_first
            assign s_in  = r_side_reg[qslerp_pkg::CORDIC_STEPS-1];
            assign vl_in = r_vld_reg[qslerp_pkg::CORDIC_STEPS-1];
        end else begin : g_next
            assign s_in  = d_side_reg[k-1];
            assign vl_in = d_vld_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_vld_reg[k] <= 1'b0;
            end else if (en) begin
                d_vld_reg[k] <= vl_in;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d_side_reg[k] <= s_in;
            end
        end
    end

    // Stage F1: pick linear or slerp weights and form the products.
    qslerp_pkg::side_t fs;
    logic signed [qslerp_pkg::WGT_W-1:0] wa, wb;
    logic f1_vld_reg, f1_lin_reg;
    logic signed [WP_W-1:0] f1_pa_reg [4];
    logic signed [WP_W-1:0] f1_pb_reg [4];

    assign fs = d_side_reg[qslerp_pkg::DIV_LAT-1];

    always_comb begin
        if (fs.lin) begin
            wa = qslerp_pkg::WGT_W'(qslerp_pkg::BLEND_ONE - fs.t);
            wb = fs.neg ? -qslerp_pkg::WGT_W'(fs.t) : qslerp_pkg::WGT_W'(fs.t);
        end else begin
            wa = div_wa;
            wb = fs.neg ? -div_wb : div_wb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= d_vld_reg[qslerp_pkg::DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_lin_reg <= fs.lin;
            for (int i = 0; i < 4; i++) begin
                f1_pa_reg[i] <= $signed(fs.a[i]) * wa;
                f1_pb_reg[i] <= $signed(fs.b[i]) * wb;
            end
        end
    end

    // Stage F2: sum, round half up and saturate to Q1.15.
    localparam logic signed [SUM_W-1:0] RND_L = SUM_W'(1) << (qslerp_pkg::BLEND_BITS - 1);
    localparam logic signed [SUM_W-1:0] RND_F = SUM_W'(1) << (qslerp_pkg::FRAC_BITS - 1);

    function automatic logic [15:0] sat16(input logic signed [SUM_W-1:0] v);
        logic [15:0] r;
        if (v > SUM_W'(32767)) begin
            r = 16'h7FFF;
        end else if (v < -SUM_W'(32768)) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic [63:0] f2_data;
    logic f2_vld_reg, f2_lin_reg;
    logic [63:0] f2_data_reg;

    always_comb begin
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] r;
        for (int i = 0; i < 4; i++) begin
            s = SUM_W'(f1_pa_reg[i]) + SUM_W'(f1_pb_reg[i]);
            r = f1_lin_reg ? ((s + RND_L) >>> qslerp_pkg::BLEND_BITS)
                           : ((s + RND_F) >>> qslerp_pkg::FRAC_BITS);
            f2_data[16*i +: 16] = sat16(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_vld_reg <= 1'b0;
        end else if (en) begin
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_data_reg <= f2_data;
            f2_lin_reg  <= f1_lin_reg;
        end
    end

    // Output register with a skid entry behind it.
    logic out_vld_reg;
    logic [63:0] out_data_reg, skid_data_reg;
    logic out_lin_reg, skid_lin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (f2_vld_reg) begin
            if (!out_vld_reg || m_tready) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                out_lin_reg  <= skid_lin_reg;
            end
        end else if (!out_vld_reg || m_tready) begin
            out_data_reg <= f2_data_reg;
            out_lin_reg  <= f2_lin_reg;
        end else begin
            skid_data_reg <= f2_data_reg;
            skid_lin_reg  <= f2_lin_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_lin_reg;

endmodule

`default_nettype wire
